### hdl/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg
// Shared types, character constants and decode helpers for the escape decoder
// ----------------------------------------------------------------------------
package cesd_pkg;

  // characters used by the decoder
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] HexTen   = 8'd10;

  // most bytes one source byte can produce
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // one decoded burst: up to MaxBytes output bytes
  typedef struct packed {
    logic [CntW-1:0]              cnt;
    logic                         last;
    logic [MaxBytes-1:0][7:0]     data;
  } cmd_t;

  typedef enum logic [4:0] {
    ModeIdle  = 5'b00001,
    ModeEsc   = 5'b00010,
    ModeX     = 5'b00100,
    ModeDigit = 5'b01000,
    ModeCopy  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } esc_t;

  function automatic hex_t hex_value(logic [7:0] c);
    hex_t   r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      r = '{valid: 1'b1, value: t[3:0]};
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      t = c - ChUpperA + HexTen;
      r = '{valid: 1'b1, value: t[3:0]};
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      t = c - ChLowerA + HexTen;
      r = '{valid: 1'b1, value: t[3:0]};
    end
    return r;
  endfunction

  function automatic esc_t simple_escape(logic [7:0] c);
    esc_t r;
    r = '{valid: 1'b1, value: c};
    case (c)
      8'h27, 8'h22, 8'h3F, 8'h5C: r.value = c;
      8'h61: r.value = 8'd7;
      8'h62: r.value = 8'd8;
      8'h66: r.value = 8'd12;
      8'h6E: r.value = 8'd10;
      8'h72: r.value = 8'd13;
      8'h74: r.value = 8'd9;
      8'h76: r.value = 8'd11;
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### hdl/cesd_front.sv
// ----------------------------------------------------------------------------
// cesd_front
// Takes source bytes, tracks escape state and emits decoded bursts
// ----------------------------------------------------------------------------
module cesd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  cesd_pkg::in_t   in_i,
  output logic            enq_o,
  output cesd_pkg::cmd_t  cmd_o
);

  cesd_pkg::mode_e mode_q, mode_d, next_mode;
  logic [7:0]      held_q, held_d;
  cesd_pkg::hex_t  cur_hex, held_hex;
  cesd_pkg::esc_t  esc;
  cesd_pkg::cmd_t  cmd;
  logic [7:0]      b;
  logic            last;

  assign b        = in_i.in_byte;
  assign last     = in_i.in_last;
  assign cur_hex  = cesd_pkg::hex_value(b);
  assign held_hex = cesd_pkg::hex_value(held_q);
  assign esc      = cesd_pkg::simple_escape(b);

  always_comb begin
    cmd       = '0;
    next_mode = cesd_pkg::ModeIdle;
    held_d    = held_q;
    unique case (mode_q)
      cesd_pkg::ModeEsc: begin
        if (esc.valid) begin
          cmd.cnt     = cesd_pkg::CntW'(1);
          cmd.data[0] = esc.value;
        end else if (b == cesd_pkg::ChX) begin
          if (last) begin
            cmd.cnt     = cesd_pkg::CntW'(2);
            cmd.data[0] = cesd_pkg::ChBslash;
            cmd.data[1] = cesd_pkg::ChX;
          end else begin
            next_mode = cesd_pkg::ModeX;
          end
        end else begin
          cmd.cnt     = cesd_pkg::CntW'(2);
          cmd.data[0] = cesd_pkg::ChBslash;
          cmd.data[1] = b;
        end
      end
      cesd_pkg::ModeX: begin
        if (!cur_hex.valid || last) begin
          cmd.cnt     = cesd_pkg::CntW'(3);
          cmd.data[0] = cesd_pkg::ChBslash;
          cmd.data[1] = cesd_pkg::ChX;
          cmd.data[2] = b;
          if (!cur_hex.valid && !last) begin
            next_mode = cesd_pkg::ModeCopy;
          end
        end else begin
          held_d    = b;
          next_mode = cesd_pkg::ModeDigit;
        end
      end
      cesd_pkg::ModeDigit: begin
        if (!held_hex.valid || !cur_hex.valid) begin
          cmd.cnt     = cesd_pkg::CntW'(4);
          cmd.data[0] = cesd_pkg::ChBslash;
          cmd.data[1] = cesd_pkg::ChX;
          cmd.data[2] = held_q;
          cmd.data[3] = b;
        end else if ({held_hex.value, cur_hex.value} == 8'h00) begin
          cmd.cnt     = cesd_pkg::CntW'(2);
          cmd.data[0] = cesd_pkg::ChBslash;
          cmd.data[1] = cesd_pkg::ChZero;
        end else begin
          cmd.cnt     = cesd_pkg::CntW'(1);
          cmd.data[0] = {held_hex.value, cur_hex.value};
        end
      end
      cesd_pkg::ModeCopy: begin
        cmd.cnt     = cesd_pkg::CntW'(1);
        cmd.data[0] = b;
      end
      default: begin
        if (b == cesd_pkg::ChBslash) begin
          if (last) begin
            cmd.cnt     = cesd_pkg::CntW'(1);
            cmd.data[0] = cesd_pkg::ChBslash;
          end else begin
            next_mode = cesd_pkg::ModeEsc;
          end
        end else begin
          cmd.cnt     = cesd_pkg::CntW'(1);
          cmd.data[0] = b;
        end
      end
    endcase
    cmd.last = last;
  end

  // a string end always drops back to idle
  always_comb begin
    mode_d = mode_q;
    if (accept_i) begin
      mode_d = last ? cesd_pkg::ModeIdle : next_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cesd_pkg::ModeIdle;
      held_q <= '0;
    end else begin
      mode_q <= mode_d;
      if (accept_i) begin
        held_q <= held_d;
      end
    end
  end

  assign enq_o = accept_i && (cmd.cnt != '0);
  assign cmd_o = cmd;

endmodule

### hdl/cesd_fifo.sv
// ----------------------------------------------------------------------------
// cesd_fifo
// Short queue of decoded bursts between front and back
// ----------------------------------------------------------------------------
module cesd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  cesd_pkg::cmd_t  wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output cesd_pkg::cmd_t  rd_data_o,
  output logic            empty_o
);

  cesd_pkg::cmd_t                   mem_q [cesd_pkg::QDepth];
  logic [cesd_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [cesd_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             do_wr, do_rd;

  assign full_o    = (cnt_q == cesd_pkg::QCntW'(cesd_pkg::QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + cesd_pkg::QCntW'(1);
      2'b01:   cnt_d = cnt_q - cesd_pkg::QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + cesd_pkg::QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + cesd_pkg::QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hdl/cesd_back.sv
// ----------------------------------------------------------------------------
// cesd_back
// Holds one burst and hands its bytes out one transfer at a time
// ----------------------------------------------------------------------------
module cesd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  cesd_pkg::cmd_t  q_data_i,
  output logic            q_rd_o,
  output logic            empty_o,
  input  logic            pop_i,
  output cesd_pkg::out_t  out_o
);

  cesd_pkg::cmd_t               cmd_q;
  logic [cesd_pkg::IdxW-1:0]    idx_q;
  logic                         busy_q;
  logic                         at_end, done, take;

  assign at_end = ({1'b0, idx_q} + cesd_pkg::CntW'(1)) == cmd_q.cnt;
  assign done   = busy_q && pop_i && at_end;
  assign take   = !q_empty_i && (!busy_q || done);
  assign q_rd_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q && pop_i) begin
        idx_q <= idx_q + cesd_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= q_data_i;
    end
  end

  assign empty_o        = !busy_q;
  assign out_o.out_byte = cmd_q.data[idx_q];
  assign out_o.out_last = cmd_q.last && at_end;

endmodule

### hdl/c_escape_string_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_string_decoder
// Streaming decoder of C string escapes, one source byte per transfer
// ----------------------------------------------------------------------------
// Input side is a queue write port: a source byte with its last flag moves
// when push is high and full is low. Output side is a queue read port: the
// oldest decoded byte sits on out_o while empty is low and moves when pop is
// high. out_last marks the final decoded byte of each string.
// A source byte yields zero to four decoded bytes. The front classifies one
// byte per cycle while full is low and writes a burst into a four-entry
// queue; the back sends one byte per cycle while pop is high. Plain text
// thus flows at one byte per cycle, each byte passing the queue and the
// back register before it shows on out_o. Multi-byte bursts back up into
// the queue and raise full; input rate is then set by the output port.
// When pop stays low, bytes wait in the back register and the queue; input
// keeps flowing until the queue fills. Reset empties the queue and returns
// the escape state to idle.
// ----------------------------------------------------------------------------
module c_escape_string_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  cesd_pkg::in_t   in_i,
  output logic            empty,
  input  logic            pop,
  output cesd_pkg::out_t  out_o
);

  logic            accept;
  logic            enq;
  cesd_pkg::cmd_t  cmd;
  cesd_pkg::cmd_t  q_data;
  logic            q_empty, q_rd;

  assign accept = push && !full;

  cesd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .enq_o    (enq),
    .cmd_o    (cmd)
  );

  cesd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (enq),
    .wr_data_i (cmd),
    .full_o    (full),
    .rd_en_i   (q_rd),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  cesd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_o     (out_o)
  );

endmodule
